// ----- design/jse_pkg.sv -----
// shared types and constants for the json string escaper
// no dependencies; used by every module of the block

package jse_pkg;

    localparam int CP_W          = 21;
    localparam int BYTE_W        = 8;
    localparam int CFG_INDEX_W   = 2;
    localparam int IDX_W         = 4;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_UNICODE_OUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_CHAR  = 2'd1;

    localparam logic [BYTE_W-1:0] DELIM_CHAR_RESET = 8'h22;

    // how the back end renders one code point
    typedef enum logic [2:0] {
        KIND_RAW,   // the byte itself
        KIND_ESC,   // backslash then one character
        KIND_U16,   // one \uXXXX unit
        KIND_PAIR,  // surrogate pair, value holds cp - 0x10000
        KIND_UTF2,
        KIND_UTF3,
        KIND_UTF4
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [CP_W-1:0]  value;
    } desc_t;

    typedef struct packed {
        logic                unicode_out;
        logic [BYTE_W-1:0]   delim_char;
    } cfg_t;

endpackage

// ----- design/jse_front.sv -----
// front end: classifies one code point into a render descriptor
// depends on jse_pkg

module jse_front
(
    input  logic [jse_pkg::CP_W-1:0] code_point,
    input  jse_pkg::cfg_t            cfg,
    output jse_pkg::desc_t           desc
);

    localparam logic [jse_pkg::CP_W-1:0] CP_BACKSPACE = 21'h08;
    localparam logic [jse_pkg::CP_W-1:0] CP_TAB       = 21'h09;
    localparam logic [jse_pkg::CP_W-1:0] CP_NEWLINE   = 21'h0A;
    localparam logic [jse_pkg::CP_W-1:0] CP_FORMFEED  = 21'h0C;
    localparam logic [jse_pkg::CP_W-1:0] CP_RETURN    = 21'h0D;
    localparam logic [jse_pkg::CP_W-1:0] CP_BACKSLASH = 21'h5C;
    localparam logic [jse_pkg::CP_W-1:0] CP_DQUOTE    = 21'h22;
    localparam logic [jse_pkg::CP_W-1:0] CP_SQUOTE    = 21'h27;
    localparam logic [jse_pkg::CP_W-1:0] CP_REPLACE   = 21'h0FFFD;
    localparam logic [jse_pkg::CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [jse_pkg::CP_W-1:0] CP_PLANE1    = 21'h10000;

    logic [jse_pkg::CP_W-1:0] cp_fixed;

    // surrogates and out of range values become the replacement char
    assign cp_fixed = ((code_point >= 21'h0D800 && code_point <= 21'h0DFFF)
                       || code_point > CP_MAX) ? CP_REPLACE : code_point;

    always_comb
    begin
        desc.kind  = jse_pkg::KIND_RAW;
        desc.value = code_point;
        case (code_point)
            CP_BACKSPACE:
            begin
                desc.kind  = jse_pkg::KIND_ESC;
                desc.value = 21'h62;
            end
            CP_TAB:
            begin
                desc.kind  = jse_pkg::KIND_ESC;
                desc.value = 21'h74;
            end
            CP_NEWLINE:
            begin
                desc.kind  = jse_pkg::KIND_ESC;
                desc.value = 21'h6E;
            end
            CP_FORMFEED:
            begin
                desc.kind  = jse_pkg::KIND_ESC;
                desc.value = 21'h66;
            end
            CP_RETURN:
            begin
                desc.kind  = jse_pkg::KIND_ESC;
                desc.value = 21'h72;
            end
            CP_BACKSLASH:
            begin
                desc.kind  = jse_pkg::KIND_ESC;
                desc.value = CP_BACKSLASH;
            end
            CP_DQUOTE, CP_SQUOTE:
            begin
                if (code_point[7:0] == cfg.delim_char)
                    desc.kind = jse_pkg::KIND_ESC;
                else
                    desc.kind = jse_pkg::KIND_RAW;
            end
            default:
            begin
                if (code_point < 21'h20)
                    desc.kind = jse_pkg::KIND_U16;
                else if (code_point < 21'h80)
                    desc.kind = jse_pkg::KIND_RAW;
                else if (cfg.unicode_out)
                begin
                    if (cp_fixed < CP_PLANE1)
                    begin
                        desc.kind  = jse_pkg::KIND_U16;
                        desc.value = cp_fixed;
                    end
                    else
                    begin
                        desc.kind  = jse_pkg::KIND_PAIR;
                        desc.value = cp_fixed - CP_PLANE1;
                    end
                end
                else
                begin
                    desc.value = cp_fixed;
                    if (cp_fixed < 21'h800)
                        desc.kind = jse_pkg::KIND_UTF2;
                    else if (cp_fixed < CP_PLANE1)
                        desc.kind = jse_pkg::KIND_UTF3;
                    else
                        desc.kind = jse_pkg::KIND_UTF4;
                end
            end
        endcase
    end

endmodule

// ----- design/jse_queue.sv -----
// short descriptor queue between front and back end
// depends on jse_pkg

module jse_queue
#(
    parameter int DEPTH = jse_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  jse_pkg::desc_t wr_desc,
    input  logic           rd_en,
    output jse_pkg::desc_t rd_desc,
    output logic           rd_valid,
    output logic           full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    jse_pkg::desc_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_desc;
    end

    assign rd_desc  = mem[rd_ptr_reg];
    assign rd_valid = (count_reg != '0);
    assign full     = (count_reg == CNT_FULL);

endmodule

// ----- design/jse_back.sv -----
// back end: walks one descriptor byte by byte into the output register
// depends on jse_pkg

module jse_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  jse_pkg::desc_t             desc,
    input  logic                       desc_valid,
    output logic                       desc_done,
    output logic [jse_pkg::BYTE_W-1:0] out_byte,
    output logic                       last,
    output logic                       empty,
    input  logic                       pop
);

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'b0, n}) : (8'h37 + {4'b0, n});
    endfunction

    function automatic logic [7:0] u16_byte(input logic [15:0] unit, input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0:    b = 8'h5C;
            3'd1:    b = 8'h75;
            3'd2:    b = hex_digit(unit[15:12]);
            3'd3:    b = hex_digit(unit[11:8]);
            3'd4:    b = hex_digit(unit[7:4]);
            3'd5:    b = hex_digit(unit[3:0]);
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    logic [jse_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    logic [jse_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                       last_reg, last_next;

    logic [jse_pkg::IDX_W-1:0]  len_m1;
    logic [jse_pkg::BYTE_W-1:0] cur_byte;
    logic [15:0]                unit_hi, unit_lo;
    logic [jse_pkg::IDX_W-1:0]  idx_lo;
    logic                       step;
    logic                       is_last;
    logic [20:0]                v;

    assign v       = desc.value;
    assign unit_hi = 16'hD800 | {6'b0, v[19:10]};
    assign unit_lo = 16'hDC00 | {6'b0, v[9:0]};
    assign idx_lo  = idx_reg - 4'd6;

    always_comb
    begin
        len_m1   = 4'd0;
        cur_byte = v[7:0];
        case (desc.kind)
            jse_pkg::KIND_RAW:
            begin
                len_m1   = 4'd0;
                cur_byte = v[7:0];
            end
            jse_pkg::KIND_ESC:
            begin
                len_m1   = 4'd1;
                cur_byte = (idx_reg == 4'd0) ? 8'h5C : v[7:0];
            end
            jse_pkg::KIND_U16:
            begin
                len_m1   = 4'd5;
                cur_byte = u16_byte(v[15:0], idx_reg[2:0]);
            end
            jse_pkg::KIND_PAIR:
            begin
                len_m1   = 4'd11;
                cur_byte = (idx_reg < 4'd6) ? u16_byte(unit_hi, idx_reg[2:0])
                                            : u16_byte(unit_lo, idx_lo[2:0]);
            end
            jse_pkg::KIND_UTF2:
            begin
                len_m1   = 4'd1;
                cur_byte = (idx_reg == 4'd0) ? {3'b110, v[10:6]} : {2'b10, v[5:0]};
            end
            jse_pkg::KIND_UTF3:
            begin
                len_m1 = 4'd2;
                case (idx_reg)
                    4'd0:    cur_byte = {4'b1110, v[15:12]};
                    4'd1:    cur_byte = {2'b10, v[11:6]};
                    default: cur_byte = {2'b10, v[5:0]};
                endcase
            end
            jse_pkg::KIND_UTF4:
            begin
                len_m1 = 4'd3;
                case (idx_reg)
                    4'd0:    cur_byte = {5'b11110, v[20:18]};
                    4'd1:    cur_byte = {2'b10, v[17:12]};
                    4'd2:    cur_byte = {2'b10, v[11:6]};
                    default: cur_byte = {2'b10, v[5:0]};
                endcase
            end
            default:
            begin
                len_m1   = 4'd0;
                cur_byte = v[7:0];
            end
        endcase
    end

    assign step      = desc_valid && (!valid_reg || pop);
    assign is_last   = (idx_reg == len_m1);
    assign desc_done = step && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (step)
        begin
            valid_next = 1'b1;
            byte_next  = cur_byte;
            last_next  = is_last;
            idx_next   = is_last ? '0 : idx_reg + 1'b1;
        end
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_byte = byte_reg;
    assign last     = last_reg;
    assign empty    = !valid_reg;

endmodule

// ----- design/json_string_escaper_unit.sv -----
// json string escaper top level: one code point in, its escaped bytes out
// path: a pushed item is written into the queue, then its bytes enter the output register
// throughput: while pop is held, one code point per cycle if each renders to a single byte;
//   an item of n bytes (1 to 12) holds the back end, one byte per cycle through the output register
// reset: asynchronous active low; clears queue, back end and output valid,
//   output mode to utf-8 and the quote character to 0x22
// depends on jse_pkg, jse_front, jse_queue, jse_back

module json_string_escaper_unit
#(
    parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input side, queue style
    input  logic                            push,
    output logic                            full,
    input  logic [jse_pkg::CP_W-1:0]        code_point,
    // result side, queue style
    output logic                            empty,
    input  logic                            pop,
    output logic [jse_pkg::BYTE_W-1:0]      out_byte,
    output logic                            last,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [jse_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [jse_pkg::BYTE_W-1:0]      cfg_data
);

    logic                       unicode_out_reg, unicode_out_next;
    logic [jse_pkg::BYTE_W-1:0] delim_char_reg, delim_char_next;
    jse_pkg::cfg_t              cfg;

    jse_pkg::desc_t front_desc;
    jse_pkg::desc_t q_desc;
    logic           q_push;
    logic           q_valid;
    logic           q_pop;

    // config writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        unicode_out_next = unicode_out_reg;
        delim_char_next  = delim_char_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                jse_pkg::REG_UNICODE_OUT: unicode_out_next = cfg_data[0];
                jse_pkg::REG_DELIM_CHAR:  delim_char_next  = cfg_data;
                default:
                begin
                    unicode_out_next = unicode_out_reg;
                    delim_char_next  = delim_char_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unicode_out_reg <= 1'b0;
            delim_char_reg  <= jse_pkg::DELIM_CHAR_RESET;
        end
        else
        begin
            unicode_out_reg <= unicode_out_next;
            delim_char_reg  <= delim_char_next;
        end
    end

    assign cfg.unicode_out = unicode_out_reg;
    assign cfg.delim_char  = delim_char_reg;

    // front end classifies the code point as it is pushed
    jse_front u_front
    (
        .code_point (code_point),
        .cfg        (cfg),
        .desc       (front_desc)
    );

    // push transaction writes the descriptor straight into the queue
    assign q_push = push && !full;

    jse_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_desc  (front_desc),
        .rd_en    (q_pop),
        .rd_desc  (q_desc),
        .rd_valid (q_valid),
        .full     (full)
    );

    // back end retires a descriptor when its last byte enters the output register
    jse_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (q_desc),
        .desc_valid (q_valid),
        .desc_done  (q_pop),
        .out_byte   (out_byte),
        .last       (last),
        .empty      (empty),
        .pop        (pop)
    );

    // a pushed item is in the queue on the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> q_valid)
        else $error("pushed item missing from queue");

    // the back end only retires a descriptor that is there
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue read while empty");

    // an item whose final byte is not yet out stays queued
    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last) |-> q_valid)
        else $error("item retired before its last byte");

endmodule
